// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define DBZ_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// consequent must hold in the cycle after the antecedent
`define DBZ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// File: hw/rtl/dbz_pkg.sv
// ----------------------------------------------------------------------------
// De Boor to Bezier package
// Coordinate format, job record passed from front to back, result codes.
// ----------------------------------------------------------------------------
package dbz_pkg;

    // signed fixed point; all operations are scale free, fraction width is moot
    localparam int COORD_BITS  = 32;
    localparam int QUEUE_DEPTH = 4;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    // index 0 = x, 1 = y, 2 = z
    typedef logic [2:0][COORD_BITS-1:0] t_point;

    // what a queued job produces
    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,  // curve too short: one flagged zero point
        KIND_END   = 2'd1,  // final junction only
        KIND_FIRST = 2'd2,  // first segment: previous g is the d0/d1 mean
        KIND_SEG   = 2'd3   // regular segment
    } t_kind;

    localparam logic [1:0] ROLE_JUNCTION = 2'd0;
    localparam logic [1:0] ROLE_INNER_F  = 2'd1;
    localparam logic [1:0] ROLE_INNER_G  = 2'd2;

    typedef struct packed {
        t_kind  kind;
        t_point older;
        t_point newer;
        t_point pt;
    } t_job;

endpackage

// File: hw/rtl/dbz_in_if.sv
// ----------------------------------------------------------------------------
// De Boor point channel
// Valid/ready channel carrying one control point and its end-of-curve flag.
// ----------------------------------------------------------------------------
interface dbz_in_if;
    import dbz_pkg::*;

    logic   valid;
    logic   ready;
    t_coord px;
    t_coord py;
    t_coord pz;
    logic   final_point;

    modport source (output valid, px, py, pz, final_point, input ready);
    modport sink   (input valid, px, py, pz, final_point, output ready);
endinterface

// File: hw/rtl/dbz_out_if.sv
// ----------------------------------------------------------------------------
// Bezier point channel
// Valid/ready channel carrying one Bezier point with its role and flags.
// ----------------------------------------------------------------------------
interface dbz_out_if;
    import dbz_pkg::*;

    logic       valid;
    logic       ready;
    t_coord     bx;
    t_coord     by;
    t_coord     bz;
    logic [1:0] role;
    logic       run_end;
    logic       too_short;

    modport source (output valid, bx, by, bz, role, run_end, too_short, input ready);
    modport sink   (input valid, bx, by, bz, role, run_end, too_short, output ready);
endinterface

// File: hw/rtl/dbz_front.sv
// ----------------------------------------------------------------------------
// De Boor to Bezier front end
// Takes control points, tracks the point count of the curve and the two
// previous points, and queues one job for every point that yields output.
// ----------------------------------------------------------------------------
module dbz_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dbz_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output dbz_pkg::t_job o_job
);
    import dbz_pkg::*;

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;
    localparam logic [1:0] SEEN_MANY = 2'd3;

    logic [1:0] r_seen, n_seen;
    t_point     r_older, r_newer;
    t_point     w_pt;
    t_kind      w_kind;
    logic       w_emit;
    logic       w_take;

    assign i_in.ready = !i_full;
    assign w_take     = i_in.valid && i_in.ready;
    assign w_pt       = {i_in.pz, i_in.py, i_in.px};

    always_comb begin
        w_kind = KIND_SEG;
        w_emit = 1'b0;
        n_seen = r_seen;
        if (i_in.final_point) begin
            w_kind = (r_seen == SEEN_MANY) ? KIND_END : KIND_SHORT;
            w_emit = 1'b1;
            n_seen = SEEN_NONE;
        end else begin
            case (r_seen)
                SEEN_NONE: n_seen = SEEN_ONE;
                SEEN_ONE:  n_seen = SEEN_TWO;
                SEEN_TWO: begin
                    w_kind = KIND_FIRST;
                    w_emit = 1'b1;
                    n_seen = SEEN_MANY;
                end
                default: begin
                    w_kind = KIND_SEG;
                    w_emit = 1'b1;
                    n_seen = SEEN_MANY;
                end
            endcase
        end
    end

    assign o_push = w_take && w_emit;
    assign o_job  = '{kind: w_kind, older: r_older, newer: r_newer, pt: w_pt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= SEEN_NONE;
        end else if (w_take) begin
            r_seen <= n_seen;
        end
    end

    // shift the point history on every item
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_older <= r_newer;
            r_newer <= w_pt;
        end
    end

endmodule

// File: hw/rtl/dbz_queue.sv
// ----------------------------------------------------------------------------
// De Boor to Bezier job queue
// Small first-in first-out store between the front end and the arithmetic.
// ----------------------------------------------------------------------------
module dbz_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dbz_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output dbz_pkg::t_job o_job,
    input  logic          i_pop
);
    import dbz_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_count <= r_count + (PTR_W+1)'(w_push) - (PTR_W+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// File: hw/rtl/dbz_back.sv
// ----------------------------------------------------------------------------
// De Boor to Bezier back end
// Three-stage pipeline forming the thirds and means of each job, followed
// by an output register that hands out the junction and inner points.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbz_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dbz_pkg::t_job i_job,
    output logic          o_pop,
    dbz_out_if.source     o_out
);
    import dbz_pkg::*;

    // floor((2a + b + 1) / 3) is done on an offset, non-negative sum that is
    // split in a high and a low half, each divided by a reciprocal multiply
    localparam int UW   = COORD_BITS + 2;
    localparam int LO_W = UW / 2;
    localparam int HI_W = UW - LO_W;
    localparam int T_W  = LO_W + 2;
    localparam int KH   = HI_W + 1;
    localparam int KT   = T_W + 1;
    localparam logic [HI_W-1:0] MH = HI_W'(((65'd1 << KH) + 65'd2) / 65'd3);
    localparam logic [T_W-1:0]  MT = T_W'(((65'd1 << KT) + 65'd2) / 65'd3);
    localparam logic signed [UW:0] OFS = (UW+1)'(3) << (COORD_BITS-1);

    // term index: 0 previous g, 1 inner f, 2 inner g
    localparam int TERM_PREV = 0;
    localparam int TERM_F    = 1;
    localparam int TERM_G    = 2;

    function automatic logic [UW-1:0] f_sum3(input t_coord a, input t_coord b);
        logic signed [UW:0] s;
        s = ((UW+1)'(a) <<< 1) + (UW+1)'(b) + (UW+1)'(1) + OFS;
        return s[UW-1:0];
    endfunction

    // (a + b) / 2 rounded to nearest, ties up
    function automatic t_coord f_mean(input t_coord a, input t_coord b);
        logic signed [COORD_BITS:0] s;
        s = (COORD_BITS+1)'(a) + (COORD_BITS+1)'(b) + (COORD_BITS+1)'(1);
        return s[COORD_BITS:1];
    endfunction

    function automatic logic [HI_W-2:0] f_hi_quot(input logic [HI_W-1:0] hi);
        logic [2*HI_W-1:0] ph;
        ph = (2*HI_W)'(hi) * (2*HI_W)'(MH);
        return ph[KH +: HI_W-1];
    endfunction

    function automatic logic [1:0] f_hi_rem(input logic [HI_W-1:0] hi,
                                            input logic [HI_W-2:0] qh);
        logic [HI_W-1:0] d;
        d = hi - (HI_W'(qh) + (HI_W'(qh) << 1));
        return d[1:0];
    endfunction

    function automatic t_coord f_third(input logic [HI_W-2:0] qh,
                                       input logic [T_W-1:0] t);
        logic [2*T_W-1:0] pt;
        logic [UW-2:0]    q;
        pt = (2*T_W)'(t) * (2*T_W)'(MT);
        q  = {qh, pt[KT +: LO_W]};
        // remove the offset: subtract half range by flipping the sign bit
        return {~q[COORD_BITS-1], q[COORD_BITS-2:0]};
    endfunction

    // stage 1: offset sums and means
    logic            r_v1;
    t_kind           r1_kind;
    logic [UW-1:0]   r1_su  [3][3];
    t_coord          r1_mlg [3];
    t_coord          r1_mnp [3];
    // stage 2: high quotient and low remainder word
    logic            r_v2;
    t_kind           r2_kind;
    logic [HI_W-2:0] r2_qh  [3][3];
    logic [T_W-1:0]  r2_t   [3][3];
    t_coord          r2_mlg [3];
    t_coord          r2_mnp [3];
    // stage 3: finished thirds
    logic            r_v3;
    t_kind           r3_kind;
    t_coord          r3_third [3][3];
    t_coord          r3_mlg [3];
    t_coord          r3_mnp [3];
    // output register
    logic            r_sv;
    t_kind           r_kind;
    logic [1:0]      r_idx;
    t_coord          r_e [3];
    t_coord          r_f [3];
    t_coord          r_g [3];

    logic            w_rdy1, w_rdy2, w_rdy3, w_take;
    logic            w_three, w_beat_last;
    logic [HI_W-2:0] w2_qh [3][3];
    logic [T_W-1:0]  w2_t  [3][3];
    t_coord          w3_third [3][3];
    t_coord          w_e [3];

    always_comb begin
        w_three     = r_kind inside {KIND_FIRST, KIND_SEG};
        w_beat_last = !w_three || (r_idx == ROLE_INNER_G);
    end

    assign w_take = !r_sv || (o_out.ready && w_beat_last);
    assign w_rdy3 = !r_v3 || w_take;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_pop  = i_valid && w_rdy1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                w2_qh[k][c]    = f_hi_quot(r1_su[k][c][UW-1:LO_W]);
                w2_t[k][c]     = {f_hi_rem(r1_su[k][c][UW-1:LO_W], w2_qh[k][c]),
                                  r1_su[k][c][LO_W-1:0]};
                w3_third[k][c] = f_third(r2_qh[k][c], r2_t[k][c]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_e[c] = f_mean((r3_kind == KIND_FIRST) ? r3_mlg[c] : r3_third[TERM_PREV][c],
                            (r3_kind == KIND_END) ? r3_mnp[c] : r3_third[TERM_F][c]);
            if (r3_kind == KIND_SHORT) begin
                w_e[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_sv  <= 1'b0;
            r_idx <= ROLE_JUNCTION;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_take) begin
                r_sv  <= r_v3;
                r_idx <= ROLE_JUNCTION;
            end else if (o_out.ready) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r1_kind <= i_job.kind;
            for (int c = 0; c < 3; c++) begin
                r1_su[TERM_PREV][c] <= f_sum3(i_job.newer[c], i_job.older[c]);
                r1_su[TERM_F][c]    <= f_sum3(i_job.newer[c], i_job.pt[c]);
                r1_su[TERM_G][c]    <= f_sum3(i_job.pt[c], i_job.newer[c]);
                r1_mlg[c]           <= f_mean(i_job.older[c], i_job.newer[c]);
                r1_mnp[c]           <= f_mean(i_job.newer[c], i_job.pt[c]);
            end
        end
        if (w_rdy2 && r_v1) begin
            r2_kind <= r1_kind;
            r2_qh   <= w2_qh;
            r2_t    <= w2_t;
            r2_mlg  <= r1_mlg;
            r2_mnp  <= r1_mnp;
        end
        if (w_rdy3 && r_v2) begin
            r3_kind  <= r2_kind;
            r3_third <= w3_third;
            r3_mlg   <= r2_mlg;
            r3_mnp   <= r2_mnp;
        end
        if (w_take && r_v3) begin
            r_kind <= r3_kind;
            r_e    <= w_e;
            r_f    <= r3_third[TERM_F];
            r_g    <= r3_third[TERM_G];
        end
    end

    always_comb begin
        o_out.valid     = r_sv;
        o_out.role      = r_idx;
        o_out.run_end   = w_beat_last;
        o_out.too_short = (r_kind == KIND_SHORT);
        case (r_idx)
            ROLE_JUNCTION: begin
                o_out.bx = r_e[0];
                o_out.by = r_e[1];
                o_out.bz = r_e[2];
            end
            ROLE_INNER_F: begin
                o_out.bx = r_f[0];
                o_out.by = r_f[1];
                o_out.bz = r_f[2];
            end
            default: begin
                o_out.bx = r_g[0];
                o_out.by = r_g[1];
                o_out.bz = r_g[2];
            end
        endcase
    end

    `DBZ_ASSERT(a_single_beat_idx, i_clk, i_rst_n, (r_sv && !w_three) |-> (r_idx == ROLE_JUNCTION))
    `DBZ_ASSERT_NEXT(a_beat_advance, i_clk, i_rst_n, (r_sv && o_out.ready && !w_beat_last), (r_sv && (r_idx == $past(r_idx) + 2'd1)))
    `DBZ_ASSERT(a_short_flags, i_clk, i_rst_n, (r_sv && (r_kind == KIND_SHORT)) |-> (o_out.run_end && (o_out.role == ROLE_JUNCTION)))

endmodule

// File: hw/rtl/deboor_to_bezier_cubic_top.sv
// ----------------------------------------------------------------------------
// Uniform cubic B-spline to Bezier converter
// Streams de Boor points in and emits junction and inner Bezier points.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake     Payload
// i_in     in   valid/ready   px, py, pz, final_point
// o_out    out  valid/ready   bx, by, bz, role, run_end, too_short
//
// A segment point yields three Bezier points, one per cycle from the output
// register while o_out.ready is high; an end or short-curve point yields one;
// the first two points of a curve yield no output.
// Reset is synchronous and clears only counters and valid flags.
// A 4-entry job queue lets input keep flowing while the output is stalled, until it fills.
// ----------------------------------------------------------------------------
module deboor_to_bezier_cubic_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dbz_in_if.sink    i_in,
    dbz_out_if.source o_out
);
    import dbz_pkg::*;

    logic w_push, w_full, w_qvalid, w_pop;
    t_job w_job, w_qjob;

    dbz_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    dbz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_job   (w_qjob),
        .i_pop   (w_pop)
    );

    dbz_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_job   (w_qjob),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
